@@ rtl/wkps_pkg.sv @@
`default_nettype none
package wkps_pkg;

  localparam int IDX_W = 16;
  localparam int PIDX_W = 10;
  localparam int DIST_W = 35;
  localparam int E_W = 17;
  localparam int COORD_W = 16;
  localparam int POINT_W = 5 * COORD_W;
  localparam logic [E_W-1:0] ONE_Q16 = 17'h10000;
  localparam int EXP_STEPS = 12;
  localparam int DRAIN_CYCLES = 8;

  localparam logic [1:0] ACT_CLEAR = 2'd0;
  localparam logic [1:0] ACT_ADD   = 2'd1;
  localparam logic [1:0] ACT_QUERY = 2'd2;

  localparam logic [1:0] REG_K_COUNT   = 2'd0;
  localparam logic [1:0] REG_SHARPNESS = 2'd1;
  localparam logic [1:0] REG_WEIGHT_3D = 2'd2;

  typedef struct packed {
    logic              v;
    logic [DIST_W-1:0] d;
    logic [IDX_W-1:0]  idx;
  } cand_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SCAN, ST_DRAIN, ST_WMUL, ST_D1GO, ST_D1WAIT,
    ST_EXP, ST_NGO, ST_NWAIT, ST_EMIT
  } state_t;

  // exp(-2^(j-8)) in Q0.16
  function automatic logic [15:0] exp_factor(input logic [3:0] j);
    logic [15:0] f;
    case (j)
      4'd0: f = 16'd65280;
      4'd1: f = 16'd65026;
      4'd2: f = 16'd64520;
      4'd3: f = 16'd63520;
      4'd4: f = 16'd61565;
      4'd5: f = 16'd57835;
      4'd6: f = 16'd51039;
      4'd7: f = 16'd39750;
      4'd8: f = 16'd24109;
      4'd9: f = 16'd8869;
      4'd10: f = 16'd1200;
      4'd11: f = 16'd22;
      default: f = 16'd0;
    endcase
    return f;
  endfunction

endpackage
`default_nettype wire

@@ rtl/weighted_knn_point_search.sv @@
// Weighted k-nearest-neighbour search over a store of 5-D Q1.15 points.
// Clear and add each give one result in the cycle after they are taken. A
// query reads the point memory once per cycle (one read port), then drains
// the distance pipeline; the K nearest settle in a row of compare-and-shift
// cells. Weights then take, per neighbour, a 13-step divider and 12 exponent
// steps, and each neighbour after the nearest is normalised by division;
// then come K results on consecutive cycles. Results cannot be stalled; each
// one is shown for one cycle with result_valid. busy is high while a query
// runs.
`default_nettype none
module weighted_knn_point_search #(
  parameter int MAX_POINTS = 1024,
  parameter int MAX_NEIGHBORS = 16
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         start,
  output logic              busy,
  input  wire logic [1:0]   action,
  input  wire logic [15:0]  coord_x,
  input  wire logic [15:0]  coord_y,
  input  wire logic [15:0]  colour_a,
  input  wire logic [15:0]  colour_b,
  input  wire logic [15:0]  colour_c,
  input  wire logic         cfg_we,
  input  wire logic [1:0]   cfg_index,
  input  wire logic [15:0]  cfg_data,
  output logic              result_valid,
  output logic [9:0]        point_index,
  output logic [34:0]       sq_distance,
  output logic [16:0]       weight,
  output logic              last,
  output logic              status
);

  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int KW = $clog2(MAX_NEIGHBORS + 1);
  localparam int KIW = (MAX_NEIGHBORS > 1) ? $clog2(MAX_NEIGHBORS) : 1;
  localparam int SW = wkps_pkg::E_W + KW;
  localparam int DIW = $clog2(wkps_pkg::DRAIN_CYCLES + 1);
  localparam int DW = wkps_pkg::DIST_W;

  wkps_pkg::state_t state, state_next;

  logic [4:0]  k_count;
  logic [15:0] sharpness;
  logic [15:0] weight_3d;

  logic [wkps_pkg::POINT_W-1:0] mem [MAX_POINTS];
  logic [wkps_pkg::POINT_W-1:0] rd_data;
  logic [wkps_pkg::POINT_W-1:0] target;
  logic [wkps_pkg::POINT_W-1:0] in_point;
  logic [AW-1:0] rd_addr;
  logic [wkps_pkg::IDX_W-1:0] rd_idx;
  logic rd_v;
  logic [CW-1:0] count;

  logic [KW-1:0] kk;
  logic [KW-1:0] kk_now;
  logic [KW-1:0] k;
  logic [DIW-1:0] dcnt;
  logic [3:0] j;

  wkps_pkg::cand_t cand;
  wkps_pkg::cand_t cell_q [MAX_NEIGHBORS];
  logic cell_take [MAX_NEIGHBORS];

  logic [51:0] num1;
  logic [12:0] q1;
  logic sat1, done1;
  logic [11:0] a_reg;
  logic ezero;
  logic [wkps_pkg::E_W-1:0] acc, acc_next;
  logic [wkps_pkg::E_W-1:0] ew [MAX_NEIGHBORS];
  logic [SW-1:0] sum;
  logic [SW-1:0] given;
  logic [16:0] q2;
  logic sat2, done2;

  logic take_in, acc_query, acc_add, acc_clear, cell_clr;
  logic d1_start, d2_start, k_last;
  logic [DW-1:0] dmin, dmax, dk;
  logic [wkps_pkg::IDX_W-1:0] idxk;

  assign busy = (state != wkps_pkg::ST_IDLE);
  assign in_point = {colour_c, colour_b, colour_a, coord_y, coord_x};

  always_comb begin
    logic [16:0] ka, kb, kc;
    ka = (k_count == '0) ? 17'd1 : 17'(k_count);
    kb = (ka > 17'(MAX_NEIGHBORS)) ? 17'(MAX_NEIGHBORS) : ka;
    kc = (kb > 17'(count)) ? 17'(count) : kb;
    kk_now = kc[KW-1:0];
  end

  assign dmin = cell_q[0].d;
  assign dmax = cell_q[KIW'(kk - 1'b1)].d;
  assign dk = cell_q[k[KIW-1:0]].d;
  assign idxk = cell_q[k[KIW-1:0]].idx;
  assign k_last = (k + 1'b1 == kk);

  // control decode
  always_comb begin
    take_in = start && !busy;
    acc_clear = take_in && (action == wkps_pkg::ACT_CLEAR);
    acc_add = take_in && (action == wkps_pkg::ACT_ADD);
    acc_query = take_in && (action == wkps_pkg::ACT_QUERY) && (count != '0);
    cell_clr = acc_query;
    d1_start = (state == wkps_pkg::ST_D1GO);
    d2_start = (state == wkps_pkg::ST_NGO);
  end

  always_comb begin
    state_next = state;
    case (state)
      wkps_pkg::ST_IDLE:   if (acc_query) state_next = wkps_pkg::ST_SCAN;
      wkps_pkg::ST_SCAN:   if (CW'(rd_addr) + 1'b1 == count) state_next = wkps_pkg::ST_DRAIN;
      wkps_pkg::ST_DRAIN:  if (dcnt == '0) state_next = wkps_pkg::ST_WMUL;
      wkps_pkg::ST_WMUL:   state_next = wkps_pkg::ST_D1GO;
      wkps_pkg::ST_D1GO:   state_next = wkps_pkg::ST_D1WAIT;
      wkps_pkg::ST_D1WAIT: if (done1) state_next = wkps_pkg::ST_EXP;
      wkps_pkg::ST_EXP: begin
        if (j == 4'(wkps_pkg::EXP_STEPS - 1)) begin
          if (!k_last) state_next = wkps_pkg::ST_WMUL;
          else if (kk == KW'(1)) state_next = wkps_pkg::ST_EMIT;
          else state_next = wkps_pkg::ST_NGO;
        end
      end
      wkps_pkg::ST_NGO:    state_next = wkps_pkg::ST_NWAIT;
      wkps_pkg::ST_NWAIT: begin
        if (done2) state_next = k_last ? wkps_pkg::ST_EMIT : wkps_pkg::ST_NGO;
      end
      wkps_pkg::ST_EMIT:   if (k_last) state_next = wkps_pkg::ST_IDLE;
      default:             state_next = wkps_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= wkps_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      k_count <= 5'd8;
      sharpness <= 16'd256;
      weight_3d <= 16'd66;
    end else if (cfg_we) begin
      case (cfg_index)
        wkps_pkg::REG_K_COUNT:   k_count <= cfg_data[4:0];
        wkps_pkg::REG_SHARPNESS: sharpness <= cfg_data;
        wkps_pkg::REG_WEIGHT_3D: weight_3d <= cfg_data;
        default: ;
      endcase
    end
  end

  // point memory
  always_ff @(posedge clk) begin
    if (acc_add && (count != CW'(MAX_POINTS))) begin
      mem[count[AW-1:0]] <= in_point;
    end
    rd_data <= mem[rd_addr];
    rd_idx <= wkps_pkg::IDX_W'(rd_addr);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      rd_v <= 1'b0;
    end else begin
      rd_v <= (state == wkps_pkg::ST_SCAN);
      if (acc_clear) begin
        count <= '0;
      end else if (acc_add && (count != CW'(MAX_POINTS))) begin
        count <= count + 1'b1;
      end
    end
  end

  wkps_dist u_dist (
    .clk    (clk),
    .rst    (rst),
    .in_v   (rd_v),
    .in_idx (rd_idx),
    .point  (rd_data),
    .target (target),
    .w3     (weight_3d),
    .out    (cand)
  );

  for (genvar i = 0; i < MAX_NEIGHBORS; i++) begin : g_cell
    if (i == 0) begin : g_head
      wkps_cell u_cell (
        .clk       (clk),
        .rst       (rst),
        .clr       (cell_clr),
        .en        (1'b1),
        .cand      (cand),
        .prev_take (1'b0),
        .prev      ('0),
        .cur       (cell_q[i]),
        .take      (cell_take[i])
      );
    end else begin : g_body
      wkps_cell u_cell (
        .clk       (clk),
        .rst       (rst),
        .clr       (cell_clr),
        .en        (KW'(i) < kk),
        .cand      (cand),
        .prev_take (cell_take[i-1]),
        .prev      (cell_q[i-1]),
        .cur       (cell_q[i]),
        .take      (cell_take[i])
      );
    end
  end

  wkps_div #(.NW(52), .DW(DW), .QW(13)) u_div_exp (
    .clk   (clk),
    .rst   (rst),
    .start (d1_start),
    .num   (num1),
    .den   (dmax),
    .quo   (q1),
    .sat   (sat1),
    .done  (done1)
  );

  wkps_div #(.NW(33), .DW(SW), .QW(17)) u_div_norm (
    .clk   (clk),
    .rst   (rst),
    .start (d2_start),
    .num   ({ew[k[KIW-1:0]], 16'd0}),
    .den   (sum),
    .quo   (q2),
    .sat   (sat2),
    .done  (done2)
  );

  always_comb begin
    logic [32:0] p;
    p = acc * wkps_pkg::exp_factor(j);
    acc_next = a_reg[j] ? 17'((p + 33'd32768) >> 16) : acc;
  end

  // weight datapath
  always_ff @(posedge clk) begin
    if (acc_query) begin
      target <= in_point;
      kk <= kk_now;
      sum <= '0;
      given <= '0;
      rd_addr <= '0;
    end
    case (state)
      wkps_pkg::ST_SCAN: begin
        dcnt <= DIW'(wkps_pkg::DRAIN_CYCLES);
        rd_addr <= rd_addr + 1'b1;
      end
      wkps_pkg::ST_DRAIN: begin
        dcnt <= dcnt - 1'b1;
        k <= '0;
      end
      wkps_pkg::ST_WMUL: begin
        num1 <= {51'(sharpness) * 51'(dk - dmin), 1'b0};
      end
      wkps_pkg::ST_D1WAIT: begin
        a_reg <= (dmax == '0) ? '0 : q1[11:0];
        ezero <= (dmax != '0) && (sat1 || q1[12]);
        acc <= wkps_pkg::ONE_Q16;
        j <= '0;
      end
      wkps_pkg::ST_EXP: begin
        acc <= acc_next;
        j <= j + 1'b1;
        if (j == 4'(wkps_pkg::EXP_STEPS - 1)) begin
          ew[k[KIW-1:0]] <= ezero ? '0 : acc_next;
          sum <= sum + SW'(ezero ? '0 : acc_next);
          if (!k_last) k <= k + 1'b1;
          else if (kk == KW'(1)) k <= '0;
          else k <= KW'(1);
        end
      end
      wkps_pkg::ST_NWAIT: begin
        if (done2) begin
          ew[k[KIW-1:0]] <= q2;
          given <= given + SW'(q2);
          k <= k_last ? '0 : k + 1'b1;
        end
      end
      wkps_pkg::ST_EMIT: begin
        k <= k + 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= acc_clear || acc_add || (state == wkps_pkg::ST_EMIT);
    end
    if (acc_add) begin
      point_index <= (count == CW'(MAX_POINTS)) ? '0 : wkps_pkg::PIDX_W'(count);
      sq_distance <= '0;
      weight <= '0;
      last <= 1'b1;
      status <= (count == CW'(MAX_POINTS));
    end else if (state == wkps_pkg::ST_EMIT) begin
      point_index <= idxk[wkps_pkg::PIDX_W-1:0];
      sq_distance <= dk;
      weight <= (k == '0) ? 17'(SW'(wkps_pkg::ONE_Q16) - given) : ew[k[KIW-1:0]];
      last <= k_last;
      status <= 1'b0;
    end else begin
      point_index <= '0;
      sq_distance <= '0;
      weight <= '0;
      last <= 1'b1;
      status <= 1'b0;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_POINTS))
    else $error("point count beyond store size");

  a_scan_in_store: assert property (@(posedge clk) disable iff (rst)
    (state == wkps_pkg::ST_SCAN) |-> (CW'(rd_addr) < count))
    else $error("scan address beyond stored points");

  a_div_done: assert property (@(posedge clk) disable iff (rst)
    done1 |-> (state == wkps_pkg::ST_D1WAIT))
    else $error("exponent divider finished outside its wait state");

  a_norm_range: assert property (@(posedge clk) disable iff (rst)
    done2 |-> !sat2)
    else $error("normalised weight out of range");

  a_refused_empty: assert property (@(posedge clk) disable iff (rst)
    (result_valid && status) |-> (point_index == '0 && weight == '0 && last))
    else $error("refused add carries payload");

  for (genvar i = 1; i < MAX_NEIGHBORS; i++) begin : g_chk
    a_sorted: assert property (@(posedge clk) disable iff (rst)
      cell_q[i].v |-> (cell_q[i-1].v && cell_q[i-1].d <= cell_q[i].d))
      else $error("neighbour cells out of order");
  end

endmodule
`default_nettype wire

@@ rtl/wkps_cell.sv @@
`default_nettype none
module wkps_cell (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           clr,
  input  wire logic           en,
  input  wkps_pkg::cand_t     cand,
  input  wire logic           prev_take,
  input  wkps_pkg::cand_t     prev,
  output wkps_pkg::cand_t     cur,
  output logic                take
);

  assign take = en && cand.v && (!cur.v || (cand.d < cur.d));

  always_ff @(posedge clk) begin
    if (rst || clr) begin
      cur.v <= 1'b0;
    end else if (prev_take) begin
      cur <= prev;
    end else if (take) begin
      cur <= cand;
    end
  end

endmodule
`default_nettype wire

@@ rtl/wkps_dist.sv @@
`default_nettype none
module wkps_dist (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_v,
  input  wire logic [wkps_pkg::IDX_W-1:0]      in_idx,
  input  wire logic [wkps_pkg::POINT_W-1:0]    point,
  input  wire logic [wkps_pkg::POINT_W-1:0]    target,
  input  wire logic [15:0]                     w3,
  output wkps_pkg::cand_t                      out
);

  localparam int CW = wkps_pkg::COORD_W;

  logic [16:0] ad [5];
  logic [16:0] ad_q [5];
  logic [31:0] sq [5];
  logic [32:0] xy_q;
  logic [33:0] col_q;
  logic [32:0] xy_q2;
  logic [49:0] prod_q;
  logic [3:0] v_p;
  logic [wkps_pkg::IDX_W-1:0] idx_p [4];

  always_comb begin
    logic signed [16:0] df;
    for (int c = 0; c < 5; c++) begin
      df = 17'(signed'(point[c*CW +: CW])) - 17'(signed'(target[c*CW +: CW]));
      ad[c] = df[16] ? 17'(-df) : 17'(df);
    end
  end

  always_ff @(posedge clk) begin
    for (int c = 0; c < 5; c++) begin
      ad_q[c] <= ad[c];
      sq[c] <= 32'(ad_q[c]) * 32'(ad_q[c]);
    end
    xy_q <= 33'(sq[0]) + 33'(sq[1]);
    col_q <= 34'(sq[2]) + 34'(sq[3]) + 34'(sq[4]);
    xy_q2 <= xy_q;
    prod_q <= col_q * w3;
    out.d <= wkps_pkg::DIST_W'(xy_q2) + wkps_pkg::DIST_W'(prod_q[49:16]);
    idx_p[0] <= in_idx;
    idx_p[1] <= idx_p[0];
    idx_p[2] <= idx_p[1];
    idx_p[3] <= idx_p[2];
    out.idx <= idx_p[3];
    if (rst) begin
      v_p <= '0;
      out.v <= 1'b0;
    end else begin
      v_p <= {v_p[2:0], in_v};
      out.v <= v_p[3];
    end
  end

endmodule
`default_nettype wire

@@ rtl/wkps_div.sv @@
`default_nettype none
module wkps_div #(
  parameter int NW = 52,
  parameter int DW = 35,
  parameter int QW = 13
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [NW-1:0] num,
  input  wire logic [DW-1:0] den,
  output logic [QW-1:0]      quo,
  output logic               sat,
  output logic               done
);

  localparam int W = (NW > DW + QW) ? NW : DW + QW;
  localparam int CNW = $clog2(QW + 1);

  logic [W-1:0] rem;
  logic [W-1:0] dsh;
  logic [CNW-1:0] cnt;
  logic ge;

  assign ge = rem >= dsh;

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= W'(num);
      dsh <= W'(den) << (QW - 1);
      sat <= W'(num) >= (W'(den) << QW);
    end else if (cnt != '0) begin
      if (ge) begin
        rem <= rem - dsh;
      end
      dsh <= dsh >> 1;
      quo <= {quo[QW-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      done <= 1'b0;
    end else begin
      done <= (cnt == CNW'(1));
      if (start) begin
        cnt <= CNW'(QW);
      end else if (cnt != '0) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire
